>>> sv/sbda_pkg.sv
// Shared types, codes and constants of the single-bin DFT accumulator.
`default_nettype none
package sbda_pkg;

    localparam int DEF_PHASE_BITS   = 16;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [40:0] AMP_MAX         = 41'h1FF_FFFF_FFFF;

    // Arctangent of 2^-i in turns, scaled by 2^32.
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_TIME_BACK   = 2'd1;
    localparam logic [1:0] STAT_NO_DURATION = 2'd2;

    localparam logic [2:0] ADDR_PHASE_STEP = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TURN,
        S_CORDIC_RUN,
        S_PROD,
        S_SCALE,
        S_COMMIT,
        S_SQUARE,
        S_SQRT,
        S_DIV,
        S_DONE
    } sbda_state_t;

endpackage
`default_nettype wire

>>> sv/sbda_cordic.sv
// Iterative rotation-mode CORDIC giving the Q1.15 cosine and sine of a turn angle.
`default_nettype none
module sbda_cordic #(
    parameter int CORDIC_STEPS = sbda_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        turn,
    output logic                    done,
    output logic signed [15:0]      cos_q,
    output logic signed [15:0]      sin_q
);
    import sbda_pkg::*;

    logic                         run_reg;
    logic                         done_reg;
    logic [ATAN_IDX_W-1:0]        cnt_reg;
    logic signed [33:0]           x_reg;
    logic signed [33:0]           y_reg;
    logic signed [33:0]           z_reg;
    logic [1:0]                   quad_reg;
    logic signed [15:0]           cos_reg;
    logic signed [15:0]           sin_reg;

    logic [31:0]                  shifted;
    logic [1:0]                   quad;
    logic [31:0]                  resid;
    logic signed [33:0]           dx;
    logic signed [33:0]           dy;
    logic signed [33:0]           atan_ext;
    logic signed [15:0]           qx;
    logic signed [15:0]           qy;

    // Rounds half away from zero to Q1.15 and clamps to +-32767.
    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic [33:0] a;
        logic [33:0] r;
        logic [15:0] m;
        begin
            a = v[33] ? 34'(-v) : v;
            r = (a + 34'd16384) >> 15;
            m = (r > 34'd32767) ? 16'd32767 : r[15:0];
            return v[33] ? 16'(-$signed(m)) : $signed(m);
        end
    endfunction

    assign shifted  = turn + 32'h2000_0000;
    assign quad     = shifted[31:30];
    assign resid    = turn - {quad, 30'b0};
    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign atan_ext = $signed({2'b00, ATAN_TURNS[cnt_reg]});
    assign qx       = to_q15(x_reg);
    assign qy       = to_q15(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == ATAN_IDX_W'(CORDIC_STEPS))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed({2'b00, CORDIC_GAIN_Q30});
            y_reg    <= '0;
            z_reg    <= $signed({{2{resid[31]}}, resid});
            quad_reg <= quad;
        end
        else if (run_reg)
        begin
            if (cnt_reg == ATAN_IDX_W'(CORDIC_STEPS))
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        cos_reg <= qx;
                        sin_reg <= qy;
                    end
                    2'd1:
                    begin
                        cos_reg <= -qy;
                        sin_reg <= qx;
                    end
                    2'd2:
                    begin
                        cos_reg <= -qx;
                        sin_reg <= -qy;
                    end
                    default:
                    begin
                        cos_reg <= qy;
                        sin_reg <= -qx;
                    end
                endcase
            end
            else if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_ext;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule
`default_nettype wire

>>> sv/single_bin_dft_accumulator.sv
// Top level of the single-bin DFT accumulator: sequencer, shared multiplier and state.
// The block takes one item at a time and holds in_stall high while it works. A sample with
// history runs the CORDIC iterations plus nine passes through the one shared 33x33
// multiplier and the saturating adds; a first sample skips the products and the scaling.
// A query makes six multiplier passes to square the integral, then a 64-step square root
// and a 65-step divide, one bit per cycle. Clear, a rejected item and an unused command go
// straight to the result. The result sits in an output register, so the next item is
// accepted while it waits.
`default_nettype none
module single_bin_dft_accumulator #(
    parameter int PHASE_BITS   = sbda_pkg::DEF_PHASE_BITS,
    parameter int CORDIC_STEPS = sbda_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [31:0]        time_req,
    input  wire logic signed [23:0] value,
    input  wire logic [31:0]        duration,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [40:0]             amplitude,
    output logic [31:0]             sample_count
);
    import sbda_pkg::*;

    localparam logic [31:0] TURN_MASK = ~((32'h1 << (32 - PHASE_BITS)) - 32'h1);
    localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MIN   = 64'h8000_0000_0000_0000;

    sbda_state_t state_reg, state_next;
    logic [6:0]  step_reg, step_next;

    logic [31:0]        phase_step_reg;
    logic signed [63:0] integ_re_reg;
    logic signed [63:0] integ_im_reg;
    logic [31:0]        last_time_reg;
    logic signed [23:0] last_value_reg;
    logic signed [15:0] last_cos_reg;
    logic signed [15:0] last_sin_reg;
    logic               have_last_reg;
    logic [31:0]        count_reg;

    logic [31:0]        time_reg;
    logic signed [23:0] value_reg;
    logic [31:0]        dur_reg;
    logic [1:0]         res_status_reg;
    logic [40:0]        res_amp_reg;
    logic signed [40:0] sr_reg;
    logic signed [40:0] si_reg;
    logic [72:0]        prod_reg;
    logic signed [63:0] inc_reg;
    logic [63:0]        abs_re_reg;
    logic [63:0]        abs_im_reg;
    logic [127:0]       wide_reg;
    logic [65:0]        rem_reg;
    logic [63:0]        root_reg;
    logic signed [65:0] mul_p_reg;

    logic               out_valid_reg;
    logic [1:0]         status_out_reg;
    logic [40:0]        amp_out_reg;
    logic [31:0]        count_out_reg;

    logic               in_acc;
    logic               out_load;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [15:0] cordic_cos;
    logic signed [15:0] cordic_sin;
    logic [1:0]         accept_status;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [31:0]        dt;
    logic [40:0]        mr;
    logic [40:0]        mi;
    logic signed [40:0] p41;
    logic [63:0]        p64;
    logic [127:0]       sq_term;
    logic [65:0]        rt_sh;
    logic [65:0]        rt_trial;
    logic               rt_take;
    logic [63:0]        root_new;
    logic [32:0]        dv_sh;
    logic               dv_take;
    logic [64:0]        quot_new;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

    // Applies the sign to an unsigned product and saturates at the 64-bit limits.
    function automatic logic signed [63:0] scale_sat(input logic [72:0] p, input logic neg);
        logic big;
        begin
            big = |p[72:63];
            if (big)
                return neg ? $signed(INT_MIN) : $signed(INT_MAX);
            else
                return neg ? 64'(-$signed(p[63:0])) : $signed(p[63:0]);
        end
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        begin
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? $signed(INT_MIN) : $signed(INT_MAX);
            else
                return s;
        end
    endfunction

    sbda_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .turn  (mul_p_reg[31:0] & TURN_MASK),
        .done  (cordic_done),
        .cos_q (cordic_cos),
        .sin_q (cordic_sin)
    );

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);
    assign dt       = time_reg - last_time_reg;
    assign mr       = sr_reg[40] ? 41'(-sr_reg) : sr_reg;
    assign mi       = si_reg[40] ? 41'(-si_reg) : si_reg;
    assign p41      = mul_p_reg[40:0];
    assign p64      = mul_p_reg[63:0];

    always_comb
    begin
        accept_status = STAT_OK;
        case (command)
            CMD_ADD:
            begin
                if (have_last_reg && time_req < last_time_reg)
                    accept_status = STAT_TIME_BACK;
            end
            CMD_QUERY:
            begin
                if (duration == 32'd0)
                    accept_status = STAT_NO_DURATION;
            end
            default:
            begin
                accept_status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (accept_status != STAT_OK)
                        state_next = S_DONE;
                    else if (command == CMD_ADD)
                        state_next = S_TURN;
                    else if (command == CMD_QUERY)
                        state_next = S_SQUARE;
                    else
                        state_next = S_DONE;
                end
            end
            S_TURN:
            begin
                if (step_reg == 7'd1)
                begin
                    cordic_start = 1'b1;
                    state_next   = S_CORDIC_RUN;
                end
            end
            S_CORDIC_RUN:
            begin
                if (cordic_done)
                    state_next = have_last_reg ? S_PROD : S_COMMIT;
            end
            S_PROD:
            begin
                if (step_reg == 7'd4)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (step_reg == 7'd6)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
            end
            S_SQUARE:
            begin
                if (step_reg == 7'd6)
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (step_reg == 7'd63)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 7'd64)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        step_next = (state_next != state_reg) ? 7'd0 : step_reg + 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TURN:
            begin
                mul_a = {1'b0, phase_step_reg};
                mul_b = {1'b0, time_reg};
            end
            S_PROD:
            begin
                case (step_reg)
                    7'd0:
                    begin
                        mul_a = {{9{last_value_reg[23]}}, last_value_reg};
                        mul_b = {{17{last_cos_reg[15]}}, last_cos_reg};
                    end
                    7'd1:
                    begin
                        mul_a = {{9{value_reg[23]}}, value_reg};
                        mul_b = {{17{cordic_cos[15]}}, cordic_cos};
                    end
                    7'd2:
                    begin
                        mul_a = {{9{last_value_reg[23]}}, last_value_reg};
                        mul_b = {{17{last_sin_reg[15]}}, last_sin_reg};
                    end
                    7'd3:
                    begin
                        mul_a = {{9{value_reg[23]}}, value_reg};
                        mul_b = {{17{cordic_sin[15]}}, cordic_sin};
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            S_SCALE:
            begin
                mul_b = {1'b0, dt};
                case (step_reg)
                    7'd0:    mul_a = {1'b0, mr[31:0]};
                    7'd1:    mul_a = {24'b0, mr[40:32]};
                    7'd2:    mul_a = {1'b0, mi[31:0]};
                    7'd3:    mul_a = {24'b0, mi[40:32]};
                    default: mul_a = '0;
                endcase
            end
            S_SQUARE:
            begin
                case (step_reg)
                    7'd0:
                    begin
                        mul_a = {1'b0, abs_re_reg[31:0]};
                        mul_b = {1'b0, abs_re_reg[31:0]};
                    end
                    7'd1:
                    begin
                        mul_a = {1'b0, abs_re_reg[63:32]};
                        mul_b = {1'b0, abs_re_reg[31:0]};
                    end
                    7'd2:
                    begin
                        mul_a = {1'b0, abs_re_reg[63:32]};
                        mul_b = {1'b0, abs_re_reg[63:32]};
                    end
                    7'd3:
                    begin
                        mul_a = {1'b0, abs_im_reg[31:0]};
                        mul_b = {1'b0, abs_im_reg[31:0]};
                    end
                    7'd4:
                    begin
                        mul_a = {1'b0, abs_im_reg[63:32]};
                        mul_b = {1'b0, abs_im_reg[31:0]};
                    end
                    7'd5:
                    begin
                        mul_a = {1'b0, abs_im_reg[63:32]};
                        mul_b = {1'b0, abs_im_reg[63:32]};
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // The cross term of a square counts twice, so it is shifted by 33 rather than 32.
    always_comb
    begin
        case (step_reg)
            7'd1, 7'd4: sq_term = {64'b0, p64};
            7'd2, 7'd5: sq_term = {31'b0, p64, 33'b0};
            7'd3, 7'd6: sq_term = {p64, 64'b0};
            default:    sq_term = '0;
        endcase
    end

    // One digit of the square root and one bit of the divide.
    assign rt_sh    = {rem_reg[63:0], wide_reg[127:126]};
    assign rt_trial = {root_reg, 2'b01};
    assign rt_take  = (rt_sh >= rt_trial);
    assign root_new = {root_reg[62:0], rt_take};
    assign dv_sh    = {rem_reg[31:0], wide_reg[64]};
    assign dv_take  = (dv_sh >= {1'b0, dur_reg});
    assign quot_new = {wide_reg[63:0], dv_take};

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
        if (in_acc)
        begin
            time_reg       <= time_req;
            value_reg      <= value;
            dur_reg        <= duration;
            res_status_reg <= accept_status;
            res_amp_reg    <= '0;
            wide_reg       <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            abs_re_reg     <= abs64(integ_re_reg);
            abs_im_reg     <= abs64(integ_im_reg);
        end
        case (state_reg)
            S_PROD:
            begin
                case (step_reg)
                    7'd1:    sr_reg <= p41;
                    7'd2:    sr_reg <= sr_reg + p41;
                    7'd3:    si_reg <= -p41;
                    7'd4:    si_reg <= si_reg - p41;
                    default: sr_reg <= sr_reg;
                endcase
            end
            S_SCALE:
            begin
                case (step_reg)
                    7'd1:
                    begin
                        prod_reg <= {9'b0, p64};
                    end
                    7'd2:
                    begin
                        prod_reg <= prod_reg + {p64[40:0], 32'b0};
                    end
                    7'd3:
                    begin
                        inc_reg  <= scale_sat(prod_reg, sr_reg[40]);
                        prod_reg <= {9'b0, p64};
                    end
                    7'd4:
                    begin
                        prod_reg <= prod_reg + {p64[40:0], 32'b0};
                    end
                    7'd5:
                    begin
                        inc_reg <= scale_sat(prod_reg, si_reg[40]);
                    end
                    default:
                    begin
                        prod_reg <= prod_reg;
                    end
                endcase
            end
            S_SQUARE:
            begin
                wide_reg <= wide_reg + sq_term;
            end
            S_SQRT:
            begin
                root_reg <= root_new;
                if (step_reg == 7'd63)
                begin
                    // Load the divide with twice the magnitude.
                    wide_reg <= {63'b0, root_new, 1'b0};
                    rem_reg  <= '0;
                end
                else
                begin
                    wide_reg <= {wide_reg[125:0], 2'b00};
                    rem_reg  <= rt_take ? rt_sh - rt_trial : rt_sh;
                end
            end
            S_DIV:
            begin
                wide_reg[64:0] <= quot_new;
                rem_reg[32:0]  <= dv_take ? dv_sh - {1'b0, dur_reg} : dv_sh;
                if (step_reg == 7'd64)
                    res_amp_reg <= (|quot_new[64:41]) ? AMP_MAX : quot_new[40:0];
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            status_out_reg <= res_status_reg;
            amp_out_reg    <= res_amp_reg;
            count_out_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            integ_re_reg   <= '0;
            integ_im_reg   <= '0;
            last_time_reg  <= '0;
            last_value_reg <= '0;
            last_cos_reg   <= '0;
            last_sin_reg   <= '0;
            have_last_reg  <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == ADDR_PHASE_STEP[2])
                phase_step_reg <= pwdata;
            if (in_acc && command == CMD_CLEAR)
            begin
                integ_re_reg   <= '0;
                integ_im_reg   <= '0;
                last_time_reg  <= '0;
                last_value_reg <= '0;
                last_cos_reg   <= '0;
                last_sin_reg   <= '0;
                have_last_reg  <= 1'b0;
                count_reg      <= '0;
            end
            if (state_reg == S_SCALE && step_reg == 7'd4)
                integ_re_reg <= sat_add(integ_re_reg, inc_reg);
            if (state_reg == S_SCALE && step_reg == 7'd6)
                integ_im_reg <= sat_add(integ_im_reg, inc_reg);
            if (state_reg == S_COMMIT)
            begin
                last_time_reg  <= time_reg;
                last_value_reg <= value_reg;
                last_cos_reg   <= cordic_cos;
                last_sin_reg   <= cordic_sin;
                have_last_reg  <= 1'b1;
                if (count_reg != 32'hFFFF_FFFF)
                    count_reg <= count_reg + 32'd1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign prdata       = (paddr[2] == ADDR_PHASE_STEP[2]) ? phase_step_reg : 32'd0;
    assign pready       = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_out_reg;
    assign amplitude    = amp_out_reg;
    assign sample_count = count_out_reg;

endmodule
`default_nettype wire

>>> sv/sbda_checker.sv
// Port-level checks of the single-bin DFT accumulator and their binding.
`default_nettype none
module sbda_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [40:0] amplitude,
    input wire logic [31:0] sample_count
);
    import sbda_pkg::*;

    // A result held back by the receiver stays as it was.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(amplitude))
        else $error("stalled result changed");

    // Every item keeps the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a second item without working on the first");

    a_amp_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> amplitude == 41'd0)
        else $error("amplitude nonzero on a failed item");

    // A sample can only be late if an earlier one was recorded.
    a_late_has_history: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_TIME_BACK |-> sample_count != 32'd0)
        else $error("late sample reported with no history");

endmodule

bind single_bin_dft_accumulator sbda_checker u_sbda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .amplitude    (amplitude),
    .sample_count (sample_count)
);
`default_nettype wire

>>> tb/single_bin_dft_accumulator_checker.sv
// Checker for the single-bin DFT accumulator: watches both channels, predicts results and compares.
`timescale 1ns / 1ps
`default_nettype none
module single_bin_dft_accumulator_checker
    import sbda_pkg::*;
#(
    parameter int PHASE_BITS   = DEF_PHASE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [31:0]        time_req,
    input  wire logic signed [23:0] value,
    input  wire logic [31:0]        duration,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         status,
    input  wire logic [40:0]         amplitude,
    input  wire logic [31:0]        sample_count,
    output int                      fail_count,
    output int                      pending_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [40:0] amplitude;
        logic [31:0] sample_count;
    } dft_result_t;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    dft_result_t expected_results[$];

    logic [31:0]   freq_step;
    longint        acc_re, acc_im;
    logic [31:0]   prev_time;
    longint        prev_value, prev_cos, prev_sin;
    logic          have_prev;
    logic [31:0]   n_samples;

    function automatic longint round_q15(longint v);
        longint r;
        if (v >= 0)
            r = (v + 16384) >>> 15;
        else
            r = -((-v + 16384) >>> 15);
        if (r > 32767)
            r = 32767;
        if (r < -32767)
            r = -32767;
        return r;
    endfunction

    // Rotation-mode CORDIC on a turn angle, quadrant folded to +-1/8 turn first.
    task automatic phase_factor(input logic [31:0] turn, output longint c, output longint s);
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy;
        quad  = 2'((turn + 32'h2000_0000) >> 30);
        resid = turn - {quad, 30'd0};
        z = longint'($signed(resid));
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        case (quad)
            2'd0:    begin c = round_q15(x);  s = round_q15(y);  end
            2'd1:    begin c = round_q15(-y); s = round_q15(x);  end
            2'd2:    begin c = round_q15(-x); s = round_q15(-y); end
            default: begin c = round_q15(y);  s = round_q15(-x); end
        endcase
    endtask

    function automatic longint sat_area(longint sum, logic [31:0] dt);
        logic signed [127:0] p;
        p = 128'(sum) * $signed({96'd0, dt});
        if (p > 128'(I64_MAX))
            return I64_MAX;
        if (p < 128'(I64_MIN))
            return I64_MIN;
        return longint'(p);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        logic signed [64:0] r;
        r = 65'(a) + 65'(b);
        if (r > 65'(I64_MAX))
            return I64_MAX;
        if (r < 65'(I64_MIN))
            return I64_MIN;
        return longint'(r);
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [40:0] amplitude_of(logic [31:0] dur);
        logic [128:0] norm, cand;
        logic [63:0]  root, q, r;
        logic [64:0]  twice;
        norm = 129'(abs64(acc_re)) * abs64(acc_re) + 129'(abs64(acc_im)) * abs64(acc_im);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = 129'(root | (64'd1 << b));
            if (cand * cand <= norm)
                root = root | (64'd1 << b);
        end
        q = root / dur;
        r = root % dur;
        if (q > 64'(AMP_MAX >> 1))
            return AMP_MAX;
        twice = 65'(r) * 2;
        return 41'(2 * q + twice / dur);
    endfunction

    task automatic predict(input logic [1:0] cmd, input logic [31:0] t,
                           input logic signed [23:0] v, input logic [31:0] dur);
        dft_result_t res;
        logic [31:0] turn;
        longint      c, s, sr, si;
        res = '0;
        if (cmd == CMD_ADD) begin
            if (have_prev && t < prev_time)
                res.status = STAT_TIME_BACK;
            else begin
                turn = freq_step * t;
                turn = (turn >> (32 - PHASE_BITS)) << (32 - PHASE_BITS);
                phase_factor(turn, c, s);
                if (have_prev) begin
                    sr = prev_value * prev_cos + longint'(v) * c;
                    si = -(prev_value * prev_sin) - longint'(v) * s;
                    acc_re = sat_sum(acc_re, sat_area(sr, t - prev_time));
                    acc_im = sat_sum(acc_im, sat_area(si, t - prev_time));
                end
                prev_time  = t;
                prev_value = longint'(v);
                prev_cos   = c;
                prev_sin   = s;
                have_prev  = 1'b1;
                if (n_samples != 32'hFFFF_FFFF)
                    n_samples++;
            end
        end
        else if (cmd == CMD_CLEAR) begin
            acc_re = 0; acc_im = 0; prev_time = '0; prev_value = 0;
            prev_cos = 0; prev_sin = 0; have_prev = 1'b0; n_samples = '0;
        end
        else if (cmd == CMD_QUERY) begin
            if (dur == 0)
                res.status = STAT_NO_DURATION;
            else
                res.amplitude = amplitude_of(dur);
        end
        res.sample_count = n_samples;
        expected_results.insert(expected_results.size(), res);
    endtask

    always @(posedge clk or negedge rst_n) begin
        dft_result_t exp_res;
        if (!rst_n) begin
            freq_step = '0; acc_re = 0; acc_im = 0; prev_time = '0; prev_value = 0;
            prev_cos = 0; prev_sin = 0; have_prev = 1'b0; n_samples = '0;
            fail_count = 0;
            expected_results.delete();
            pending_count = 0;
        end
        else begin
            if (psel && penable && pwrite && paddr == ADDR_PHASE_STEP)
                freq_step = pwdata;
            if (in_valid && !in_stall)
                predict(command, time_req, value, duration);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d amplitude=%0d count=%0d",
                             $time, status, amplitude, sample_count);
                    fail_count++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status || amplitude !== exp_res.amplitude
                        || sample_count !== exp_res.sample_count) begin
                        $display("%0t: mismatch expected status=%0d amplitude=%0d count=%0d",
                                 $time, exp_res.status, exp_res.amplitude,
                                 exp_res.sample_count);
                        $display("%0t:          actual   status=%0d amplitude=%0d count=%0d",
                                 $time, status, amplitude, sample_count);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule
`default_nettype wire

>>> tb/single_bin_dft_accumulator_tb.sv
// Testbench top of the single-bin DFT accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module single_bin_dft_accumulator_tb;
    import sbda_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = CMD_ADD;
    logic [31:0]        time_req = '0;
    logic signed [23:0] value = '0;
    logic [31:0]        duration = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [40:0]        amplitude;
    logic [31:0]        sample_count;
    int                 fail_count, pending_count;
    int                 send_idle_pct = 0, recv_idle_pct = 0;
    longint             cycle_count = 0;
    logic [31:0]        cur_time = '0;

    always #5 clk = ~clk;

    single_bin_dft_accumulator i_dut (.*);

    single_bin_dft_accumulator_checker i_checker (.*);

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_phase_step(input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_PHASE_STEP; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Stop sending, wait until every expected result is in, then for the longest query time.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // The valid stays high after an item is taken until the next item or an idle cycle.
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] t,
                             input logic signed [23:0] v, input logic [31:0] dur);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; command <= cmd; time_req <= t; value <= v; duration <= dur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            1:       return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        logic [31:0] step;
        int          r;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                step = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5000);
                if ($urandom_range(19) == 0 && cur_time > 0)
                    send_item(CMD_ADD, cur_time - 32'($urandom_range(1, 100)),
                              rand_value(), $urandom);
                else begin
                    cur_time = (32'hFFFF_FFFF - cur_time < step) ? 32'hFFFF_FFFF
                                                                 : cur_time + step;
                    send_item(CMD_ADD, cur_time, rand_value(), $urandom);
                end
            end
            else if (r < 90)
                send_item(CMD_QUERY, $urandom,
                          ($urandom_range(9) == 0) ? 24'sh0 : 24'($urandom),
                          ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1) ? $urandom
                          : $urandom_range(1, 1000));
            else if (r < 96) begin
                cur_time = $urandom_range(1000);
                send_item(CMD_CLEAR, $urandom, 24'($urandom), $urandom);
            end
            else
                send_item(CMD_NOP, $urandom, 24'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first sample, equal times, backward time, extremes, every command.
        write_phase_step(32'h0100_0000);
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_ADD, 32'd10, 24'sh7FFFFF, 0);
        send_item(CMD_ADD, 32'd10, 24'sh800000, 0);
        send_item(CMD_ADD, 32'd5, 24'sd1, 0);
        send_item(CMD_ADD, 32'd40, -24'sd1, 0);
        send_item(CMD_QUERY, 0, 0, 32'd1);
        send_item(CMD_QUERY, 32'hFFFF_FFFF, 24'sh7FFFFF, 32'hFFFF_FFFF);
        send_item(CMD_NOP, 32'hFFFF_FFFF, -24'sd1, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 24'sh800000, 0);
        send_item(CMD_QUERY, 0, 0, 32'd3);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_ADD, 32'd0, 24'sh7FFFFF, 0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 24'sh7FFFFF, 0);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 24'sh7FFFFF, 0);
        send_item(CMD_QUERY, 0, 0, 32'd1);
        drain();
        write_phase_step(32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 24'sh800000, 0);
        send_item(CMD_QUERY, 0, 0, 32'd2);
        send_item(CMD_CLEAR, 0, 0, 0);
        drain();

        write_phase_step(32'h0012_3457);
        cur_time = 0;
        send_idle_pct = 19; recv_idle_pct = 46;
        random_phase(400);
        drain();
        write_phase_step($urandom);
        send_idle_pct = 46; recv_idle_pct = 19;
        random_phase(400);
        drain();
        write_phase_step(32'd0);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(350);
        drain();
        write_phase_step($urandom_range(1, 1 << 20));
        random_phase(350);
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

>>> single_bin_dft_accumulator.f
sv/sbda_pkg.sv
sv/sbda_cordic.sv
sv/single_bin_dft_accumulator.sv
sv/sbda_checker.sv
tb/single_bin_dft_accumulator_checker.sv
tb/single_bin_dft_accumulator_tb.sv
